// ===== design/upsa_pkg.sv =====
// ----------------------------------------------------------------------------
// upsa_pkg
// Shared types and constants for the alpha unpremultiply / swizzle block.
// ----------------------------------------------------------------------------
package upsa_pkg;

    localparam int CFG_W  = 13;
    localparam int POS_W  = 12;
    localparam int CHAN_W = 8;
    localparam int REM_W  = 17;
    localparam int NUM_CH = 3;

    // channel slots inside the pipeline, already in output order
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [CHAN_W-1:0] OPAQUE_ALPHA      = 8'd255;
    localparam logic [CHAN_W-1:0] SEE_THROUGH_ALPHA = 8'd192;
    localparam logic [CHAN_W-1:0] CHAN_MAX          = 8'd255;

    typedef enum logic [1:0] {
        CFG_BOX_LEFT   = 2'd0,
        CFG_BOX_TOP    = 2'd1,
        CFG_BOX_WIDTH  = 2'd2,
        CFG_BOX_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] in_blue;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_alpha;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } pix_out_t;

    // one colour channel in flight through the restoring divider
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [CHAN_W-1:0] quo;
        logic              sat;
    } chan_t;

    typedef struct packed {
        chan_t [NUM_CH-1:0] ch;
        logic [REM_W-1:0]   dsh;
        logic               zero;
        logic               opaque;
    } div_item_t;

endpackage

// ===== design/unpremultiply_swizzle_alpha_box.sv =====
// ----------------------------------------------------------------------------
// unpremultiply_swizzle_alpha_box
// Premultiplied BGRA to straight RGBA with an opaque-rectangle alpha.
// ----------------------------------------------------------------------------
// an accepted request is registered in the front stage, then in each divider stage
// throughput: one pixel per cycle while out_stall is low; four two-bit divider stages after the front
// stall from the output reaches back combinationally through full stages only, bubbles are squeezed
// reset clears all stage valid bits and the four box registers to zero
// ----------------------------------------------------------------------------
module unpremultiply_swizzle_alpha_box
    import upsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  pix_in_t          in_pix,
    output logic             out_valid,
    input  logic             out_stall,
    output pix_out_t         out_pix
);

    localparam int NUM_STAGES = 4;

    logic                   front_ready;
    logic [NUM_STAGES:0]    stg_valid;
    div_item_t              stg_item [NUM_STAGES+1];
    logic [NUM_STAGES:0]    stg_ready;
    div_item_t              last;

    upsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .valid_in  (in_valid),
        .pix_in    (in_pix),
        .ready_out (front_ready),
        .valid_out (stg_valid[0]),
        .item_out  (stg_item[0]),
        .ready_in  (stg_ready[0])
    );

    // divider pipeline
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_div
        upsa_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stg_valid[i]),
            .item_in   (stg_item[i]),
            .ready_out (stg_ready[i]),
            .valid_out (stg_valid[i+1]),
            .item_out  (stg_item[i+1]),
            .ready_in  (stg_ready[i+1])
        );
    end

    assign stg_ready[NUM_STAGES] = !out_stall;
    assign in_stall              = !front_ready;
    assign out_valid             = stg_valid[NUM_STAGES];
    assign last                  = stg_item[NUM_STAGES];

    // zero alpha, saturation and alpha selection
    always_comb
    begin
        if (last.zero)
        begin
            out_pix.out_red   = '0;
            out_pix.out_green = '0;
            out_pix.out_blue  = '0;
        end
        else
        begin
            out_pix.out_red   = last.ch[CH_RED].sat ? CHAN_MAX : last.ch[CH_RED].quo;
            out_pix.out_green = last.ch[CH_GREEN].sat ? CHAN_MAX : last.ch[CH_GREEN].quo;
            out_pix.out_blue  = last.ch[CH_BLUE].sat ? CHAN_MAX : last.ch[CH_BLUE].quo;
        end
        out_pix.out_alpha = last.opaque ? OPAQUE_ALPHA : SEE_THROUGH_ALPHA;
    end

    a_out_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_pix.out_alpha == OPAQUE_ALPHA) ||
                      (out_pix.out_alpha == SEE_THROUGH_ALPHA))
        else $error("output alpha neither opaque nor see-through");

    a_in_stall_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    a_result_delay: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("request lost in pipeline");

endmodule

// ===== design/upsa_front.sv =====
// ----------------------------------------------------------------------------
// upsa_front
// Config registers, box test and divider setup; first pipeline register.
// ----------------------------------------------------------------------------
module upsa_front
    import upsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              valid_in,
    input  pix_in_t           pix_in,
    output logic              ready_out,
    output logic              valid_out,
    output div_item_t         item_out,
    input  logic              ready_in
);

    logic [CFG_W-1:0] box_left_reg;
    logic [CFG_W-1:0] box_top_reg;
    logic [CFG_W-1:0] box_width_reg;
    logic [CFG_W-1:0] box_height_reg;
    logic             valid_reg;
    div_item_t        item_reg;
    div_item_t        item_next;
    logic [CFG_W:0]   x_end;
    logic [CFG_W:0]   y_end;
    logic             in_x;
    logic             in_y;

    // numerator 510*v + a, saturation test against 2a*256
    function automatic chan_t start_chan(input logic [CHAN_W-1:0] v,
                                         input logic [CHAN_W-1:0] a);
        logic [17:0] num;
        logic [17:0] lim;
        chan_t       c;
        num   = {1'b0, v, 9'b0} - {9'b0, v, 1'b0} + {10'b0, a};
        lim   = {1'b0, a, 9'b0};
        c.rem = num[REM_W-1:0];
        c.quo = '0;
        c.sat = (num >= lim);
        return c;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_width_reg  <= '0;
            box_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_BOX_LEFT:   box_left_reg   <= cfg_data;
                CFG_BOX_TOP:    box_top_reg    <= cfg_data;
                CFG_BOX_WIDTH:  box_width_reg  <= cfg_data;
                CFG_BOX_HEIGHT: box_height_reg <= cfg_data;
            endcase
        end
    end

    // box test with full precision end points
    always_comb
    begin
        x_end = {1'b0, box_left_reg} + {1'b0, box_width_reg};
        y_end = {1'b0, box_top_reg} + {1'b0, box_height_reg};
        in_x  = ({1'b0, pix_in.pos_x} >= box_left_reg) &&
                ({2'b0, pix_in.pos_x} < x_end);
        in_y  = ({1'b0, pix_in.pos_y} >= box_top_reg) &&
                ({2'b0, pix_in.pos_y} < y_end);
    end

    // divider setup, channels placed in rgba order
    always_comb
    begin
        item_next.ch[CH_RED]   = start_chan(pix_in.in_red,   pix_in.in_alpha);
        item_next.ch[CH_GREEN] = start_chan(pix_in.in_green, pix_in.in_alpha);
        item_next.ch[CH_BLUE]  = start_chan(pix_in.in_blue,  pix_in.in_alpha);
        item_next.dsh          = {1'b0, pix_in.in_alpha, 8'b0};
        item_next.zero         = (pix_in.in_alpha == '0);
        item_next.opaque       = in_x && in_y;
    end

    assign ready_out = !valid_reg || ready_in;

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

// ===== design/upsa_div_stage.sv =====
// ----------------------------------------------------------------------------
// upsa_div_stage
// Two restoring-division steps for all three channels, one pipeline register.
// ----------------------------------------------------------------------------
module upsa_div_stage
    import upsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid_in,
    input  div_item_t item_in,
    output logic      ready_out,
    output logic      valid_out,
    output div_item_t item_out,
    input  logic      ready_in
);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;
    logic      bound_ok;

    // two quotient bits; divisor shifts right after each
    always_comb
    begin
        item_next = item_in;
        for (int s = 0; s < 2; s++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (item_next.ch[c].rem >= item_next.dsh)
                begin
                    item_next.ch[c].rem = item_next.ch[c].rem - item_next.dsh;
                    item_next.ch[c].quo = {item_next.ch[c].quo[CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    item_next.ch[c].quo = {item_next.ch[c].quo[CHAN_W-2:0], 1'b0};
                end
            end
            item_next.dsh = item_next.dsh >> 1;
        end
    end

    assign ready_out = !valid_reg || ready_in;

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

    // remainder stays below twice the current divisor for in-range channels
    always_comb
    begin
        bound_ok = 1'b1;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (!item_reg.zero && !item_reg.ch[c].sat &&
                ({1'b0, item_reg.ch[c].rem} >= {item_reg.dsh, 1'b0}))
            begin
                bound_ok = 1'b0;
            end
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !ready_in |=> valid_reg && $stable(item_reg))
        else $error("stage item changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(valid_in))
        else $error("stage became valid without an upstream request");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> bound_ok)
        else $error("division remainder out of range");

endmodule

// ===== sim/unpremultiply_swizzle_alpha_box_tb.sv =====
// ----------------------------------------------------------------------------
// unpremultiply_swizzle_alpha_box_tb
// Self-checking bench for the BGRA unpremultiply and RGBA swizzle block.
// Pixels are sent through the valid/stall input and predicted in the bench:
// each colour is rounded as (2*v*255 + a) / (2*a) and saturated, zero alpha
// gives black, and output alpha follows the opaque box. Results are matched
// in order against the predictions. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unpremultiply_swizzle_alpha_box_tb;
    import upsa_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    pix_in_t          in_pix;
    logic             out_valid;
    logic             out_stall = 1'b0;
    pix_out_t         out_pix;

    // bench copy of the opaque box registers
    logic [CFG_W-1:0] box_l;
    logic [CFG_W-1:0] box_t;
    logic [CFG_W-1:0] box_w;
    logic [CFG_W-1:0] box_h;

    pix_out_t pending_rgba[$];
    int       mismatches = 0;
    logic     tx_idle_en = 1'b1;
    logic     rx_idle_en = 1'b1;
    int       stall_run  = 0;

    unpremultiply_swizzle_alpha_box u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pix    (in_pix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pix   (out_pix)
    );

    // 20 ns clock
    always #10 clk = ~clk;

    // straight colour from a premultiplied byte, half away from zero
    function automatic logic [CHAN_W-1:0] unpremul_chan(logic [CHAN_W-1:0] v,
                                                        logic [CHAN_W-1:0] a);
        int unsigned quo;
        if (a == '0)
        begin
            return '0;
        end
        quo = (2 * 255 * int'(v) + int'(a)) / (2 * int'(a));
        return (quo > 255) ? CHAN_MAX : quo[CHAN_W-1:0];
    endfunction

    // box test with full-width end positions, no wrap
    function automatic logic in_box(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        logic [CFG_W:0] x_end;
        logic [CFG_W:0] y_end;
        x_end = {1'b0, box_l} + {1'b0, box_w};
        y_end = {1'b0, box_t} + {1'b0, box_h};
        return ({1'b0, x} >= box_l) && ({2'b0, x} < x_end) &&
               ({1'b0, y} >= box_t) && ({2'b0, y} < y_end);
    endfunction

    function automatic pix_out_t straight_rgba(pix_in_t p);
        pix_out_t o;
        o.out_red   = unpremul_chan(p.in_red, p.in_alpha);
        o.out_green = unpremul_chan(p.in_green, p.in_alpha);
        o.out_blue  = unpremul_chan(p.in_blue, p.in_alpha);
        o.out_alpha = in_box(p.pos_x, p.pos_y) ? OPAQUE_ALPHA : SEE_THROUGH_ALPHA;
        return o;
    endfunction

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // coordinate near a box edge, inside it, or anywhere
    function automatic logic [POS_W-1:0] pick_coord(int lo, int span);
        int c;
        case ($urandom_range(0, 3))
            0:       c = lo - 1 + $urandom_range(0, 2);
            1:       c = lo + span - 1 + $urandom_range(0, 2);
            2:       c = lo + ((span > 0) ? $urandom_range(0, span - 1) : 0);
            default: c = $urandom_range(0, 4095);
        endcase
        if (c < 0 || c > 4095)
        begin
            c = $urandom_range(0, 4095);
        end
        return c[POS_W-1:0];
    endfunction

    // mostly well-formed premultiplied pixels, some zero alpha, some broken
    function automatic pix_in_t rand_pixel();
        pix_in_t     p;
        int unsigned kind;
        kind       = $urandom_range(0, 99);
        p.in_alpha = CHAN_W'($urandom_range(0, 255));
        p.in_red   = CHAN_W'($urandom_range(0, 255));
        p.in_green = CHAN_W'($urandom_range(0, 255));
        p.in_blue  = CHAN_W'($urandom_range(0, 255));
        if (kind < 70)
        begin
            p.in_red   = CHAN_W'($urandom_range(0, p.in_alpha));
            p.in_green = CHAN_W'($urandom_range(0, p.in_alpha));
            p.in_blue  = CHAN_W'($urandom_range(0, p.in_alpha));
        end
        else if (kind < 76)
        begin
            p.in_alpha = '0;
        end
        p.pos_x = pick_coord(box_l, box_w);
        p.pos_y = pick_coord(box_t, box_h);
        return p;
    endfunction

    // send one request, optional gap first, holds until accepted
    task automatic push_pixel(pix_in_t p);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 1) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_rgba.push_back(straight_rgba(p));
        in_valid <= 1'b1;
        in_pix   <= p;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // stop sending and wait for every pending result
    task automatic wait_all_done();
        in_valid <= 1'b0;
        while (pending_rgba.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // program the opaque box while the block is idle
    task automatic set_box(logic [CFG_W-1:0] l, logic [CFG_W-1:0] t,
                           logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_all_done();
        @(posedge clk);
        box_l = l;
        box_t = t;
        box_w = w;
        box_h = h;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BOX_LEFT;
        cfg_data  <= l;
        @(posedge clk);
        cfg_index <= CFG_BOX_TOP;
        cfg_data  <= t;
        @(posedge clk);
        cfg_index <= CFG_BOX_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_BOX_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random colour at a fixed position
    task automatic probe_at(int x, int y);
        pix_in_t p;
        p       = rand_pixel();
        p.pos_x = POS_W'(x);
        p.pos_y = POS_W'(y);
        push_pixel(p);
    endtask

    // colour rounding, saturation and zero alpha, box off
    task automatic test_channel_math();
        push_pixel(pix_in_t'{8'd255, 8'd255, 8'd255, 8'd0, 12'd0, 12'd0});
        push_pixel(pix_in_t'{8'd0, 8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095});
        push_pixel(pix_in_t'{8'd255, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd0});
        push_pixel(pix_in_t'{8'd0, 8'd128, 8'd255, 8'd255, 12'd0, 12'd4095});
        push_pixel(pix_in_t'{8'd1, 8'd0, 8'd1, 8'd1, 12'd1, 12'd1});
        push_pixel(pix_in_t'{8'd2, 8'd200, 8'd255, 8'd1, 12'd2, 12'd2});
        push_pixel(pix_in_t'{8'd1, 8'd1, 8'd1, 8'd2, 12'd2048, 12'd1024});
        push_pixel(pix_in_t'{8'd1, 8'd2, 8'd3, 8'd3, 12'd2730, 12'd1365});
        push_pixel(pix_in_t'{8'd200, 8'd150, 8'd250, 8'd100, 12'd100, 12'd200});
        push_pixel(pix_in_t'{8'd127, 8'd64, 8'd1, 8'd128, 12'd3000, 12'd7});
        push_pixel(pix_in_t'{8'h55, 8'hAA, 8'h0F, 8'hF0, 12'hAAA, 12'h555});
    endtask

    // box borders, box past the image edge, empty and whole-image boxes
    task automatic test_box_edges();
        set_box(13'd10, 13'd20, 13'd5, 13'd3);
        probe_at(9, 20);
        probe_at(10, 20);
        probe_at(14, 22);
        probe_at(15, 20);
        probe_at(10, 19);
        probe_at(10, 23);
        set_box(13'd4090, 13'd4090, 13'd4096, 13'd4096);
        probe_at(4095, 4095);
        probe_at(4089, 4095);
        probe_at(4090, 4090);
        set_box(13'd0, 13'd0, 13'd4096, 13'd4096);
        probe_at(0, 0);
        probe_at(4095, 4095);
        set_box(13'd4096, 13'd4096, 13'd4096, 13'd4096);
        probe_at(4095, 4095);
        set_box(13'd100, 13'd100, 13'd0, 13'd50);
        probe_at(100, 100);
    endtask

    // random pixels over several box settings and idle patterns
    task automatic test_random_stream();
        int l;
        int t;
        int w;
        int h;
        for (int phase = 0; phase < 8; phase++)
        begin
            l = $urandom_range(0, 4096);
            t = $urandom_range(0, 4096);
            w = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 4096);
            h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 4096);
            if (phase == 0)
            begin
                l = 4096;
                t = 4096;
                w = 4096;
                h = 4096;
            end
            else if (phase == 1)
            begin
                l = 0;
                t = 0;
                w = 0;
                h = 0;
            end
            set_box(CFG_W'(l), CFG_W'(t), CFG_W'(w), CFG_W'(h));
            tx_idle_en = (phase % 4 == 1) || (phase % 4 == 2);
            rx_idle_en = (phase % 4 == 1) || (phase % 4 == 3);
            for (int n = 0; n < 116; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                begin
                    wait_all_done();
                end
                push_pixel(rand_pixel());
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // output back-pressure in runs of stall and release
    always @(posedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run--;
        end
        else if (rx_idle_en && $urandom_range(0, 2) == 0)
        begin
            out_stall <= 1'b1;
            stall_run = idle_len() - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_run = rx_idle_en ? $urandom_range(0, 6) : 0;
        end
    end

    task automatic check_field(string name, logic [CHAN_W-1:0] want,
                               logic [CHAN_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rgba.size() == 0)
            begin
                $error("out_pix: result with no request pending");
                mismatches++;
            end
            else
            begin
                want = pending_rgba.pop_front();
                check_field("out_red", want.out_red, out_pix.out_red);
                check_field("out_green", want.out_green, out_pix.out_green);
                check_field("out_blue", want.out_blue, out_pix.out_blue);
                check_field("out_alpha", want.out_alpha, out_pix.out_alpha);
            end
        end
    end

    // main sequence
    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_BOX_LEFT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_pix    = '0;
        box_l     = '0;
        box_t     = '0;
        box_w     = '0;
        box_h     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_channel_math();
        test_box_edges();
        test_random_stream();

        wait_all_done();
        repeat (12) @(posedge clk);
        if (mismatches == 0 && pending_rgba.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
